### rtl/core/assert_macros.svh
// Assertion macros used by the checker of the scheduler core.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define PS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define PS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/psched_pkg.sv
// Shared constants, types and helper functions of the tick scheduler core.
// No dependencies; used by psched_cell, the top level and the checker.
`default_nettype none
package psched_pkg;
    localparam int MAX_TASKS = 16;
    localparam int WORK_BITS = 16;
    localparam int IDX_W     = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NAME_W    = 8;
    localparam int CD_W      = 16;
    localparam int LVL_W     = 8;

    localparam logic [NAME_W-1:0] IDLE_NAME = 8'd46;
    localparam logic [1:0]        POLICY_RR = 2'd2;
    localparam logic              CMD_LOAD  = 1'b0;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1;
    localparam logic [2:0] OP_ADMIT  = 3'd2;
    localparam logic [2:0] OP_RETIRE = 3'd3;
    localparam logic [2:0] OP_RUN    = 3'd4;

    typedef struct packed {
        logic [2:0]           op;
        logic [IDX_W-1:0]     sel;
        logic [NAME_W-1:0]    name;
        logic [WORK_BITS-1:0] work;
        logic [CD_W-1:0]      cd;
        logic [LVL_W-1:0]     lvl;
        logic                 rr;
        logic [IDX_W-1:0]     pos;
        logic [IDX_W-1:0]     lpos;
        logic [IDX_W-1:0]     ref_rpos;
        logic [IDX_W-1:0]     ref_lpos;
        logic                 move_head;
        logic                 end_en;
    } t_cell_cmd;

    typedef struct packed {
        logic                 valid;
        logic                 in_run;
        logic [NAME_W-1:0]    name;
        logic [WORK_BITS-1:0] work;
        logic [CD_W-1:0]      cd;
        logic [LVL_W-1:0]     lvl;
        logic                 rr;
        logic [IDX_W-1:0]     rpos;
        logic [IDX_W-1:0]     wpos;
        logic [IDX_W-1:0]     lpos;
    } t_cell_state;

    function automatic logic [IDX_W-1:0] lowest_idx(input logic [MAX_TASKS-1:0] mask);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (mask[i]) r = IDX_W'(i);
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] popcnt(input logic [MAX_TASKS-1:0] mask);
        logic [CNT_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
            r = r + CNT_W'(mask[i]);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/core/psched_cell.sv
// One task slot of the scheduler row: holds the slot state and applies broadcast commands.
// Depends on psched_pkg; passes the free-slot search to its upper neighbor.
`default_nettype none
module psched_cell (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [psched_pkg::IDX_W-1:0] i_idx,
    input  wire psched_pkg::t_cell_cmd  i_cmd,
    input  wire logic                   i_free_in,
    output logic                        o_free_out,
    output logic                        o_take,
    output psched_pkg::t_cell_state     o_state
);
    psched_pkg::t_cell_state r_s, n_s;
    logic me, in_wait;

    assign me         = (i_idx == i_cmd.sel);
    assign in_wait    = r_s.valid && !r_s.in_run;
    assign o_take     = !r_s.valid && !i_free_in;
    assign o_free_out = i_free_in || !r_s.valid;
    assign o_state    = r_s;

    always_comb begin
        n_s = r_s;
        unique case (i_cmd.op)
            psched_pkg::OP_LOAD: begin
                if (me) begin
                    n_s.valid  = 1'b1;
                    n_s.in_run = (i_cmd.cd == '0);
                    n_s.name   = i_cmd.name;
                    n_s.work   = i_cmd.work;
                    n_s.cd     = i_cmd.cd;
                    n_s.lvl    = i_cmd.lvl;
                    n_s.rr     = i_cmd.rr;
                    n_s.rpos   = i_cmd.pos;
                    n_s.wpos   = i_cmd.pos;
                    n_s.lpos   = i_cmd.lpos;
                end else if (i_cmd.cd != '0) begin
                    if (in_wait && r_s.wpos >= i_cmd.pos) n_s.wpos = r_s.wpos + 1'b1;
                end else begin
                    if (r_s.valid && r_s.in_run && r_s.rpos >= i_cmd.pos)
                        n_s.rpos = r_s.rpos + 1'b1;
                end
            end
            psched_pkg::OP_ADMIT: begin
                if (me) begin
                    n_s.in_run = 1'b1;
                    n_s.rpos   = i_cmd.pos;
                end else begin
                    // close the gap left by the wait head
                    if (in_wait && r_s.wpos != '0) n_s.wpos = r_s.wpos - 1'b1;
                    if (r_s.valid && r_s.in_run && r_s.rpos >= i_cmd.pos)
                        n_s.rpos = r_s.rpos + 1'b1;
                end
            end
            psched_pkg::OP_RETIRE: begin
                if (i_cmd.end_en && me) begin
                    n_s.valid  = 1'b0;
                    n_s.in_run = 1'b0;
                end else if (i_cmd.end_en && r_s.valid) begin
                    if (r_s.lvl == i_cmd.lvl && r_s.lpos > i_cmd.ref_lpos)
                        n_s.lpos = r_s.lpos - 1'b1;
                    if (r_s.in_run && r_s.rpos > i_cmd.ref_rpos)
                        n_s.rpos = r_s.rpos - 1'b1;
                end
                if (in_wait && r_s.cd != '0) n_s.cd = r_s.cd - 1'b1;
            end
            psched_pkg::OP_RUN: begin
                if (me) begin
                    if (i_cmd.rr) n_s.lpos = i_cmd.lpos;
                    if (i_cmd.move_head) n_s.rpos = '0;
                    if (r_s.work != '0) n_s.work = r_s.work - 1'b1;
                end else if (r_s.valid) begin
                    if (i_cmd.rr && r_s.lvl == i_cmd.lvl && r_s.lpos > i_cmd.ref_lpos)
                        n_s.lpos = r_s.lpos - 1'b1;
                    if (i_cmd.move_head && r_s.in_run && r_s.rpos < i_cmd.ref_rpos)
                        n_s.rpos = r_s.rpos + 1'b1;
                end
            end
            default: begin
                n_s = r_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s.valid  <= 1'b0;
            r_s.in_run <= 1'b0;
        end else begin
            r_s <= n_s;
        end
    end
endmodule
`default_nettype wire

### rtl/core/priority_fifo_rr_tick_scheduler_core.sv
// Top level of the tick scheduler: sequencer and reductions over a row of slot cells.
// Depends on psched_pkg and psched_cell.
//
//  channel  | handshake              | words
//  ---------+------------------------+-----------------------------------------------
//  command  | start in, busy out     | i_cmd i_task_name i_work_units i_arrival_delay
//           |                        | i_priority_level i_policy
//  result   | o_valid strobe, 1 cyc  | o_run_name o_idle o_finished o_load_rejected
//
// A load passes through the LOAD state before its result is registered. A tick steps through
// HEAD, ADMIT, RETIRE and PICK, and through RUN as well when a task runs; ADMIT repeats for each
// waiting task admitted that tick, and the admit step handles one task per cycle.
// busy is high from accept until the result strobe; no new word is taken meanwhile.
// Synchronous reset clears all slots; the core is ready on the cycle after reset.
// Results cannot be stalled.
`default_nettype none
module priority_fifo_rr_tick_scheduler_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_task_name,
    input  wire logic [15:0] i_work_units,
    input  wire logic [15:0] i_arrival_delay,
    input  wire logic [7:0]  i_priority_level,
    input  wire logic [1:0]  i_policy,
    output logic             o_valid,
    output logic [7:0]       o_run_name,
    output logic             o_idle,
    output logic             o_finished,
    output logic             o_load_rejected
);
    localparam int N  = psched_pkg::MAX_TASKS;
    localparam int IW = psched_pkg::IDX_W;
    localparam int CW = psched_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_HEAD   = 3'd2;
    localparam logic [2:0] ST_ADMIT  = 3'd3;
    localparam logic [2:0] ST_RETIRE = 3'd4;
    localparam logic [2:0] ST_PICK   = 3'd5;
    localparam logic [2:0] ST_RUN    = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_end_vld, n_end_vld;
    logic [IW-1:0] r_end_idx, r_pick, r_head;
    logic [7:0]  r_name, r_lvl;
    logic [15:0] r_work, r_cd;
    logic        r_rr;

    psched_pkg::t_cell_cmd   cmd;
    psched_pkg::t_cell_state s [N];
    logic [N:0]   chain;
    logic [N-1:0] take, hd, wh, rmask, wmask, pmask, pk, lmatch, run_v, wait_v;
    logic [IW-1:0] free_idx, head_idx, wh_idx, pick_idx, best, run_ins, wait_ins;
    logic [7:0]   ins_lvl, lvl_h, lvl_q;
    logic [CW-1:0] run_len, wait_len, lvl_cnt;
    logic         full, admit_go;

    assign chain[0] = 1'b0;
    assign full     = !chain[N];

    for (genvar g = 0; g < N; g++) begin : g_cell
        psched_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_idx      (IW'(g)),
            .i_cmd      (cmd),
            .i_free_in  (chain[g]),
            .o_free_out (chain[g+1]),
            .o_take     (take[g]),
            .o_state    (s[g])
        );
    end

    always_comb begin
        hd = '0; wh = '0; run_v = '0; wait_v = '0;
        free_idx = '0; head_idx = '0; wh_idx = '0;
        for (int i = 0; i < N; i++) begin
            run_v[i]  = s[i].valid && s[i].in_run;
            wait_v[i] = s[i].valid && !s[i].in_run;
            hd[i]     = run_v[i] && s[i].rpos == '0;
            wh[i]     = wait_v[i] && s[i].wpos == '0;
            if (take[i]) free_idx = IW'(i);
            if (hd[i])   head_idx = IW'(i);
            if (wh[i])   wh_idx   = IW'(i);
        end
        run_len  = psched_pkg::popcnt(run_v);
        wait_len = psched_pkg::popcnt(wait_v);
    end

    // insertion points (first position whose task sorts after the new one) and the pick
    always_comb begin
        ins_lvl = (r_state == ST_LOAD) ? r_lvl : s[wh_idx].lvl;
        lvl_q   = (r_state == ST_LOAD) ? r_lvl : s[r_pick].lvl;
        lvl_h   = s[head_idx].lvl;
        rmask = '0; wmask = '0; pmask = '0; lmatch = '0;
        for (int i = 0; i < N; i++) begin
            if (run_v[i] && s[i].lvl > ins_lvl) rmask[s[i].rpos] = 1'b1;
            if (wait_v[i] && s[i].cd > r_cd)    wmask[s[i].wpos] = 1'b1;
            if (run_v[i] && s[i].lvl == lvl_h)  pmask[s[i].lpos] = 1'b1;
            lmatch[i] = s[i].valid && s[i].lvl == lvl_q;
        end
        run_ins  = (|rmask) ? psched_pkg::lowest_idx(rmask) : IW'(run_len);
        wait_ins = (|wmask) ? psched_pkg::lowest_idx(wmask) : IW'(wait_len);
        best     = psched_pkg::lowest_idx(pmask);
        lvl_cnt  = psched_pkg::popcnt(lmatch);
        pk = '0; pick_idx = '0;
        for (int i = 0; i < N; i++) begin
            pk[i] = run_v[i] && s[i].lvl == lvl_h && s[i].lpos == best;
            if (pk[i]) pick_idx = IW'(i);
        end
    end

    assign admit_go = (|wh) && s[wh_idx].cd == '0;

    always_comb begin
        cmd = '0;
        cmd.op = psched_pkg::OP_NONE;
        unique case (r_state)
            ST_LOAD: begin
                cmd.op   = full ? psched_pkg::OP_NONE : psched_pkg::OP_LOAD;
                cmd.sel  = free_idx;
                cmd.name = r_name;
                cmd.work = psched_pkg::WORK_BITS'(r_work);
                cmd.cd   = r_cd;
                cmd.lvl  = r_lvl;
                cmd.rr   = r_rr;
                cmd.pos  = (r_cd != '0) ? wait_ins : run_ins;
                cmd.lpos = IW'(lvl_cnt);
            end
            ST_ADMIT: begin
                cmd.op  = admit_go ? psched_pkg::OP_ADMIT : psched_pkg::OP_NONE;
                cmd.sel = wh_idx;
                cmd.pos = run_ins;
            end
            ST_RETIRE: begin
                cmd.op       = psched_pkg::OP_RETIRE;
                cmd.end_en   = r_end_vld;
                cmd.sel      = r_end_idx;
                cmd.lvl      = s[r_end_idx].lvl;
                cmd.ref_lpos = s[r_end_idx].lpos;
                cmd.ref_rpos = s[r_end_idx].rpos;
            end
            ST_RUN: begin
                cmd.op        = psched_pkg::OP_RUN;
                cmd.sel       = r_pick;
                cmd.rr        = s[r_pick].rr;
                cmd.lvl       = s[r_pick].lvl;
                cmd.ref_lpos  = s[r_pick].lpos;
                cmd.ref_rpos  = s[r_pick].rpos;
                cmd.lpos      = IW'(lvl_cnt - CW'(1));
                cmd.move_head = (r_pick != r_head);
            end
            default: begin
                cmd.op = psched_pkg::OP_NONE;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_end_vld = r_end_vld;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = (i_cmd == psched_pkg::CMD_LOAD) ? ST_LOAD : ST_HEAD;
            end
            ST_LOAD:   n_state = ST_IDLE;
            ST_HEAD: begin
                n_end_vld = (|hd) && s[head_idx].work == '0;
                n_state   = ST_ADMIT;
            end
            ST_ADMIT:  n_state = admit_go ? ST_ADMIT : ST_RETIRE;
            ST_RETIRE: n_state = ST_PICK;
            ST_PICK:   n_state = (|hd) ? ST_RUN : ST_IDLE;
            ST_RUN:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    assign busy = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_end_vld <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_end_vld <= n_end_vld;
            o_valid   <= (r_state == ST_LOAD) || (r_state == ST_RUN)
                      || (r_state == ST_PICK && !(|hd));
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && start) begin
            r_name <= i_task_name;
            r_work <= i_work_units;
            r_cd   <= i_arrival_delay;
            r_lvl  <= i_priority_level;
            r_rr   <= (i_policy == psched_pkg::POLICY_RR);
        end
        if (r_state == ST_HEAD) r_end_idx <= head_idx;
        if (r_state == ST_PICK) begin
            r_pick <= pick_idx;
            r_head <= head_idx;
        end
        unique case (r_state)
            ST_LOAD: begin
                o_run_name      <= '0;
                o_idle          <= 1'b0;
                o_finished      <= 1'b0;
                o_load_rejected <= full;
            end
            ST_PICK: begin
                o_run_name      <= psched_pkg::IDLE_NAME;
                o_idle          <= 1'b1;
                o_finished      <= (wait_len == '0);
                o_load_rejected <= 1'b0;
            end
            ST_RUN: begin
                o_run_name      <= s[r_pick].name;
                o_idle          <= 1'b0;
                o_finished      <= 1'b0;
                o_load_rejected <= 1'b0;
            end
            default: begin
                o_run_name <= o_run_name;
            end
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/psched_checker.sv
// Port-level checker for the tick scheduler core, bound to the top level.
// Depends on assert_macros.svh and psched_pkg.
`default_nettype none
`include "assert_macros.svh"
module psched_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_valid,
    input wire logic [7:0] o_run_name,
    input wire logic       o_idle,
    input wire logic       o_finished,
    input wire logic       o_load_rejected
);
    logic fin_word, rej_word, idle_word, clean_rej;

    assign fin_word  = o_valid && o_finished;
    assign rej_word  = o_valid && o_load_rejected;
    assign idle_word = o_idle && (o_run_name == psched_pkg::IDLE_NAME);
    assign clean_rej = !o_idle && !o_finished;

    `PS_ASSERT_IMP(a_fin_idle, i_clk, i_rst_n, fin_word, idle_word, "finish without idle")
    `PS_ASSERT_IMP(a_rej_excl, i_clk, i_rst_n, rej_word, clean_rej, "reject with tick flags")
    `PS_ASSERT_NXT(a_acc_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")
    `PS_ASSERT_IMP(a_res_free, i_clk, i_rst_n, o_valid, !busy, "result strobe while busy")
    `PS_ASSERT_NXT(a_one_res, i_clk, i_rst_n, o_valid, !o_valid, "result strobe too long")
endmodule

bind priority_fifo_rr_tick_scheduler_core psched_checker u_psched_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_run_name      (o_run_name),
    .o_idle          (o_idle),
    .o_finished      (o_finished),
    .o_load_rejected (o_load_rejected)
);
`default_nettype wire
